@@ rtl/see_pkg.sv @@
// see_pkg: shared types and constants for the stack expression evaluator
// item structs, queue command, operation and status codes, back-end states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package see_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_BADCH = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned DIV_SW      = 5;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [2:0]  status;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_XOR,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_FETCH,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/stack_expression_evaluator.sv @@
// stack_expression_evaluator: top level of the postfix / prefix stack evaluator
// depends on see_pkg, see_front, see_queue, see_back
//
// usage
// - in channel: one ASCII character per request (in_item.char_code) with
//   in_item.last marking the end of an expression; taken when in_valid and
//   not in_stall; in_stall rises when the four-entry command queue is full
// - out channel: one result per expression (value, status), held in an
//   output register until taken with out_valid high and out_stall low
// - cfg channel: cfg_data sets notation (0 postfix, 1 prefix fed last
//   character first); cfg_ready is always high
// - sequencing: the back end steps a digit or bad character through fetch
//   and done, + - ^ through fetch, exec and done, * through an added mul
//   state and / through an added div state that waits for the divider (one
//   quotient bit per cycle); characters after an error go fetch then done;
//   out_valid rises at the edge that closes the last character
// - the stack is one memory with one write and one read port plus a top
//   register, so an operator reads the operand below the top from the read port
// - reset clears the queue, stack count, error and output valid; no
//   clearing pass is needed
// - while out_stall holds a result, the next expression runs on until its
//   own last character, which waits for the output register to free up
`timescale 1ns / 1ps
`default_nettype none

module stack_expression_evaluator import see_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 128
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_item,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data
);

    logic notation_reg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_wdata;
    cmd_t q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notation_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            notation_reg <= cfg_data;
        end
    end

    see_front u_front
    (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    see_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    see_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .notation  (notation_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

@@ rtl/see_front.sv @@
// see_front: accepts characters and classifies them into queue commands
// depends on see_pkg
`timescale 1ns / 1ps
`default_nettype none

module see_front import see_pkg::*;
(
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    output logic          q_push,
    output cmd_t          q_data,
    input  wire logic     q_full
);

    op_t op;

    always_comb
    begin
        unique case (in_item.char_code) inside
            [CH_ZERO:CH_NINE]: op = OP_DIGIT;
            CH_PLUS:           op = OP_ADD;
            CH_MINUS:          op = OP_SUB;
            CH_STAR:           op = OP_MUL;
            CH_SLASH:          op = OP_DIV;
            CH_CARET:          op = OP_XOR;
            default:           op = OP_BAD;
        endcase
    end

    assign in_stall     = q_full;
    assign q_push       = in_valid && !q_full;
    assign q_data.op    = op;
    assign q_data.digit = in_item.char_code[3:0];
    assign q_data.last  = in_item.last;

endmodule

`default_nettype wire

@@ rtl/see_queue.sv @@
// see_queue: short command queue between front and back
// depends on see_pkg
`timescale 1ns / 1ps
`default_nettype none

module see_queue import see_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      empty
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/see_div.sv @@
// see_div: iterative signed 32-bit divider, truncating, one quotient bit per cycle
// depends on see_pkg
`timescale 1ns / 1ps
`default_nettype none

module see_div import see_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_SW-1:0] step_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       quo_reg;
    logic [31:0]       den_reg;
    logic              neg_reg;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic [31:0]       rem_next;
    logic [31:0]       quo_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, den_reg};
        if (!diff[32])
        begin
            rem_next = diff[31:0];
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = trial[31:0];
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + DIV_SW'(1);
                if (step_reg == DIV_SW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend[31] ? -req.dividend : req.dividend;
            den_reg <= req.divisor[31] ? -req.divisor : req.divisor;
            neg_reg <= req.dividend[31] ^ req.divisor[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -quo_reg : quo_reg;

endmodule

`default_nettype wire

@@ rtl/see_back.sv @@
// see_back: executes queued commands on the operand stack and forms results
// depends on see_pkg and see_div
`timescale 1ns / 1ps
`default_nettype none

module see_back import see_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 128
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic notation,
    input  wire logic q_empty,
    input  wire cmd_t q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_item
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    logic [31:0]   mem [STACK_DEPTH];
    logic [31:0]   rd_data_reg;

    back_state_t   state_reg;
    back_state_t   state_next;
    cmd_t          cur_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [2:0]    err_reg;
    logic [2:0]    err_next;
    logic [31:0]   tos_reg;
    logic [31:0]   tos_next;
    logic [31:0]   prod_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_item_reg;
    out_item_t     out_item_next;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          mem_we;
    logic          out_free;
    logic          few;
    logic          full;
    logic [31:0]   opl;
    logic [31:0]   opr;
    logic [31:0]   alu;
    logic [63:0]   prod_full;
    logic [2:0]    fin_status;
    div_req_t      div_req;
    div_rsp_t      div_rsp;

    see_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cnt_m1    = cnt_reg - CW'(1);
    assign cnt_m2    = cnt_reg - CW'(2);
    assign few       = (cnt_reg < CW'(2));
    assign full      = (cnt_reg == CW'(STACK_DEPTH));
    assign out_free  = !out_valid_reg || !out_stall;
    assign opl       = notation ? tos_reg : rd_data_reg;
    assign opr       = notation ? rd_data_reg : tos_reg;
    assign prod_full = opl * opr;

    always_comb
    begin
        case (cur_reg.op)
            OP_ADD:  alu = opl + opr;
            OP_SUB:  alu = opl - opr;
            default: alu = opl ^ opr;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_FETCH:
            begin
                if (!q_empty)
                begin
                    if (err_reg != ST_OK || q_data.op == OP_DIGIT
                        || q_data.op == OP_BAD || few)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (cur_reg.op == OP_MUL)
                begin
                    state_next = S_MUL;
                end
                else if (cur_reg.op == OP_DIV && opr != '0)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!cur_reg.last || out_free)
                begin
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_FETCH;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop            = 1'b0;
        cnt_next         = cnt_reg;
        err_next         = err_reg;
        tos_next         = tos_reg;
        mem_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = opl;
        div_req.divisor  = opr;
        out_valid_next   = out_valid_reg && out_stall;
        out_item_next    = out_item_reg;
        fin_status       = err_reg;
        if (err_reg == ST_OK && cnt_reg == '0)
        begin
            fin_status = ST_UNDER;
        end
        unique case (state_reg)
            S_FETCH:
            begin
                q_pop = !q_empty;
                if (!q_empty && err_reg == ST_OK)
                begin
                    if (q_data.op == OP_DIGIT)
                    begin
                        if (full)
                        begin
                            err_next = ST_OVER;
                        end
                        else
                        begin
                            mem_we   = (cnt_reg != '0);
                            tos_next = {28'd0, q_data.digit};
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    else if (q_data.op == OP_BAD)
                    begin
                        err_next = ST_BADCH;
                    end
                    else if (few)
                    begin
                        err_next = ST_UNDER;
                    end
                end
            end
            S_EXEC:
            begin
                if (cur_reg.op == OP_DIV)
                begin
                    if (opr == '0)
                    begin
                        err_next = ST_DIVZ;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                    end
                end
                else if (cur_reg.op != OP_MUL)
                begin
                    tos_next = alu;
                    cnt_next = cnt_m1;
                end
            end
            S_MUL:
            begin
                tos_next = prod_reg;
                cnt_next = cnt_m1;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    tos_next = div_rsp.quotient;
                    cnt_next = cnt_m1;
                end
            end
            S_DONE:
            begin
                if (cur_reg.last && out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_item_next.status = fin_status;
                    out_item_next.value  = (fin_status == ST_OK) ? tos_reg : '0;
                    cnt_next             = '0;
                    err_next             = ST_OK;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FETCH;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg      <= tos_next;
        out_item_reg <= out_item_next;
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (state_reg == S_EXEC)
        begin
            prod_reg <= prod_full[31:0];
        end
    end

    // stack below the top entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_m1[AW-1:0]] <= tos_reg;
        end
        rd_data_reg <= mem[cnt_m2[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

@@ rtl/see_checker.sv @@
// see_checker: port-level checks on the stack expression evaluator
// depends on see_pkg; bound to stack_expression_evaluator
`timescale 1ns / 1ps
`default_nettype none

module see_checker import see_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_item,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
        else $error("stalled request changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.status == ST_OK || out_item.status == ST_UNDER
                       || out_item.status == ST_OVER || out_item.status == ST_DIVZ
                       || out_item.status == ST_BADCH))
        else $error("status code out of range");

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |-> out_item.value == '0)
        else $error("nonzero value with error status");

endmodule

bind stack_expression_evaluator see_checker u_see_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
